// ----- src/sha1s_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types and constants for the SHA-1 stream hash engine.
// ----------------------------------------------------------------------------
package sha1s_pkg;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      case (idx)
         3'd0:    init_word = H0;
         3'd1:    init_word = H1;
         3'd2:    init_word = H2;
         3'd3:    init_word = H3;
         default: init_word = H4;
      endcase
   endfunction

   // control from sequencer to round unit
   typedef struct packed {
      logic       start;   // load a..e from chaining words
      logic       step;    // one round with w_in
      logic [6:0] round;
      logic       fold;    // add a..e into chaining words
      logic       init;    // chaining words back to initial values
   } rnd_ctl_type;

endpackage

// ----- src/sha1_stream_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_stream_hash
// SHA-1 engine fed one message byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: one transaction per byte (mode absorb) or a finish
//  (mode finish). rsp_ channel: five digest words after each finish,
//  word_index 0..4, last_word on the fifth.
//  Absorb: a byte transaction is taken while the engine is idle.
//  The 64th byte of a block starts a compression: the 64 bytes are read into
//  the 16-word window, a..e are loaded, 80 rounds run and the result is folded;
//  req_stall stays high from that byte until the fold is done.
//  Finish: the pad byte takes the accept cycle, then one zero write per
//  cycle up to byte 56 (first through byte 63 plus a compression when fewer
//  than 8 bytes remain), 8 length writes, a final compression, then 5 result
//  transactions, one per cycle without stalls.
//  The round unit is the shared iterative loop; the byte RAM has one read
//  and one write port, which sets the load time of the schedule.
//  Reset: chaining words to initial values, counters cleared, block RAM
//  left undefined. When rsp_stall is high the current word holds and the
//  engine waits; req_stall stays high while a block or finish runs.
// ----------------------------------------------------------------------------
module sha1_stream_hash import sha1s_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PAD  = 4'd1;  // zero fill
   localparam logic [3:0] ST_LEN  = 4'd2;  // length bytes
   localparam logic [3:0] ST_LOAD = 4'd3;  // read bytes into W window
   localparam logic [3:0] ST_RND  = 4'd4;
   localparam logic [3:0] ST_FOLD = 4'd5;
   localparam logic [3:0] ST_OUT  = 4'd6;
   localparam logic [3:0] ST_STRT = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic        fin_ff, fin_in;     // finishing message
   logic        last_ff, last_in;   // block being compressed is final
   logic [6:0]  cnt_ff, cnt_in;     // generic counter
   logic [31:0] w_ff [16];
   logic [31:0] w_in_v [16];
   logic [2:0]  oidx_ff, oidx_in;

   logic        wr_en;
   logic [5:0]  wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;
   rnd_ctl_type ctl;
   logic [31:0] h_out;
   logic [63:0] bits;
   logic [31:0] wnext;
   logic [5:0]  ld_addr;            // byte address whose data lands now
   logic [3:0]  ld_word;

   sha1s_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   sha1s_round u_rnd (
      .clock(clock), .reset(reset), .ctl(ctl), .w_in(w_ff[0]),
      .h_sel(oidx_ff), .h_out(h_out)
   );

   assign bits  = {total_ff, 3'b000};
   assign wnext = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];

   assign ld_addr = cnt_ff[5:0] - 6'd1;
   assign ld_word = ld_addr[5:2];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = '{digest_word: h_out, word_index: oidx_ff,
                        last_word: (oidx_ff == 3'd4)};

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      oidx_in  = oidx_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff;
      wr_data  = req_data.data_byte;
      rd_addr  = cnt_ff[5:0];
      ctl      = '0;
      ctl.round = cnt_ff;
      for (int i = 0; i < 16; i++) w_in_v[i] = w_ff[i];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               wr_en = 1'b1;
               if (req_data.mode == MODE_ABSORB) begin
                  total_in = total_ff + 61'd1;
                  fill_in  = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     last_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  wr_data = PAD_BYTE;
                  fin_in  = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     last_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_PAD: begin
            // zero up to 56, or to 64 then compress an extra block
            wr_en   = 1'b1;
            wr_data = 8'h00;
            if (fill_ff == 6'd56 && !last_ff && fill_ff != 6'd0) begin
               wr_en    = 1'b0;
               cnt_in   = '0;
               state_in = ST_LEN;
            end else begin
               fill_in = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  last_in  = 1'b0;
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LEN: begin
            wr_en   = 1'b1;
            wr_data = bits[8*(7-cnt_ff[2:0]) +: 8];
            fill_in = fill_ff + 6'd1;
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff[2:0] == 3'd7) begin
               last_in  = 1'b1;
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // cnt = byte address read; its data lands in the next cycle
            rd_addr = cnt_ff[5:0];
            if (cnt_ff != 7'd0) begin
               w_in_v[ld_word] = {w_ff[ld_word][23:0], rd_data};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               w_in_v[15] = {w_ff[15][23:0], rd_data};
               state_in   = ST_STRT;
            end
         end
         ST_STRT: begin
            ctl.start = 1'b1;
            cnt_in    = '0;
            state_in  = ST_RND;
         end
         ST_RND: begin
            ctl.step = 1'b1;
            for (int i = 0; i < 15; i++) w_in_v[i] = w_ff[i+1];
            w_in_v[15] = {wnext[30:0], wnext[31]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd79) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            ctl.fold = 1'b1;
            fill_in  = '0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (last_ff) begin
               oidx_in  = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd4) begin
                  ctl.init = 1'b1;
                  fill_in  = '0;
                  total_in = '0;
                  fin_in   = 1'b0;
                  last_in  = 1'b0;
                  oidx_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         total_ff <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         cnt_ff   <= '0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         cnt_ff   <= cnt_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 16; i++) w_ff[i] <= w_in_v[i];
   end

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(oidx_ff)))
      else $error("digest word dropped under stall");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_word) |-> (oidx_ff == 3'd4))
      else $error("last flag misplaced");
`endif
endmodule

// ----- src/sha1s_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha1s_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/sha1s_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1s_round
// SHA-1 round datapath: working registers a..e and chaining words H0..H4.
// ----------------------------------------------------------------------------
module sha1s_round import sha1s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rnd_ctl_type ctl,
   input  logic [31:0] w_in,
   input  logic [2:0]  h_sel,
   output logic [31:0] h_out
);
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] h_ff [5];
   logic [31:0] f, k, tmp;

   always_comb begin
      if (ctl.round < 7'd20) begin
         f = (b_ff & c_ff) ^ (~b_ff & d_ff);
         k = K0;
      end else if (ctl.round < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (ctl.round < 7'd60) begin
         f = (b_ff & c_ff) ^ (b_ff & d_ff) ^ (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
      tmp = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + w_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff <= h_ff[0];
         b_ff <= h_ff[1];
         c_ff <= h_ff[2];
         d_ff <= h_ff[3];
         e_ff <= h_ff[4];
      end else if (ctl.step) begin
         e_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff;
         a_ff <= tmp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.init) begin
         for (int i = 0; i < 5; i++) h_ff[i] <= init_word(3'(i));
      end else if (ctl.fold) begin
         h_ff[0] <= h_ff[0] + a_ff;
         h_ff[1] <= h_ff[1] + b_ff;
         h_ff[2] <= h_ff[2] + c_ff;
         h_ff[3] <= h_ff[3] + d_ff;
         h_ff[4] <= h_ff[4] + e_ff;
      end
   end

   assign h_out = (h_sel > 3'd4) ? h_ff[4] : h_ff[h_sel];
endmodule
